[hdl/oxcal_pkg.sv]
// Shared widths, constants and codes for the oxygen cell averaging and calibration block.
`default_nettype none
package oxcal_pkg;

  localparam int WINDOW  = 10;

  localparam int CODE_W  = 16;
  localparam int MAG_W   = 15;
  localparam int GAIN_W  = 24;
  localparam int CFG_W   = 24;
  localparam int TENTH_W = 10;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 2;

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = $clog2(32767 * WINDOW + 1);
  localparam int DIV_W   = (SUM_W > GAIN_W) ? SUM_W : GAIN_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int PROD_W  = MAG_W + GAIN_W;

  localparam logic [CODE_W-1:0] CELL_MIN_RST = 16'd112;
  localparam logic [CODE_W-1:0] CELL_MAX_RST = 16'd240;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 24'd86016;
  localparam logic [GAIN_W-1:0] GAIN_SAT     = 24'hFFFFFF;
  localparam logic [DIV_W-1:0]  CAL_NUM      = DIV_W'(209 << 16);
  localparam logic [TENTH_W-1:0] TENTHS_MAX  = 10'd1000;
  localparam logic [TENTH_W-1:0] TENTHS_LIM  = 10'd999;

  typedef enum logic [IDX_W-1:0] {
    REG_CELL_MIN = 2'd0,
    REG_CELL_MAX = 2'd1,
    REG_INIT_GAIN = 2'd2
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NORMAL    = 2'd0,
    ST_CAL       = 2'd1,
    ST_CELL_FLT  = 2'd2,
    ST_CAL_FLT   = 2'd3
  } status_t;

endpackage
`default_nettype wire

[hdl/oxygen_cell_average_calibrate.sv]
// Top level: ring-buffer moving average, one-point calibration and oxygen readout.
//
// Usage: present a sample on in_adc_code / in_button_level with in_valid; it
// transfers when in_stall is low. One result transfers on the out_ channel
// for every sample, when out_valid is high and out_stall is low.
// The shared restoring divider yields one quotient bit per cycle over a
// 24-bit dividend: one pass for the average, and a second pass for the gain
// when the button falls on a nonzero average and a new gain is computed.
// One item is in work at a time; the next sample can transfer once the
// result sits in the output register. A stalled receiver holds at most one
// result and then the input. The ten samples live in a small synchronous
// RAM, read in the cycle before the update that subtracts the oldest entry
// and writes the newest. Configuration writes (cfg_valid/cfg_ready) are to
// go in only while idle; the block itself does not enforce this. Index 2
// also loads the gain in force. Reset (rst_n low, synchronous) empties the
// window, restores the register defaults and the default gain, and marks
// the button as released. No clearing pass is needed: an entry is read only
// once written.
`default_nettype none
module oxygen_cell_average_calibrate import oxcal_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [CODE_W-1:0] in_adc_code,
  input  wire logic                 in_button_level,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STAT_W-1:0]         out_status,
  output logic [TENTH_W-1:0]        out_o2_tenths,
  output logic [CODE_W-1:0]         out_average_code,
  output logic [GAIN_W-1:0]         out_gain,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;

  logic [MAG_W-1:0]    ring_mem [WINDOW];
  logic [MAG_W-1:0]    rd_data_r;
  logic                ring_rd, ring_we;

  logic [CODE_W-1:0]   cell_min_r, cell_max_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    count_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                last_button_r;

  logic [MAG_W-1:0]    mag_r;
  logic                edge_r;
  logic [MAG_W-1:0]    avg_r;
  logic [PROD_W-1:0]   prod_r;

  logic [DIV_W-1:0]    div_q_r;
  logic [CODE_W-1:0]   div_rem_r;
  logic [CODE_W-1:0]   div_den_r;
  logic [DCNT_W-1:0]   div_cnt_r;
  logic                div_gain_r;

  logic                in_xfer;
  logic [MAG_W-1:0]    mag_in;
  logic [CODE_W:0]     trial;
  logic                trial_ge;
  logic [CODE_W-1:0]   rem_nxt;
  logic [DIV_W-1:0]    q_nxt;
  logic                full;
  logic [SUM_W-1:0]    sum_nxt;
  logic [CNT_W-1:0]    count_nxt;
  logic [PROD_W-17:0]  tenths_w;
  logic                out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // absolute value, most negative code clamps to the largest positive one
  always_comb begin
    if (in_adc_code[CODE_W-1]) begin
      if (in_adc_code == {1'b1, {(CODE_W-1){1'b0}}}) mag_in = {MAG_W{1'b1}};
      else mag_in = MAG_W'(-in_adc_code);
    end else begin
      mag_in = in_adc_code[MAG_W-1:0];
    end
  end

  assign full      = (count_r == CNT_W'(WINDOW));
  assign sum_nxt   = sum_r - (full ? SUM_W'(rd_data_r) : '0) + SUM_W'(mag_r);
  assign count_nxt = full ? count_r : count_r + CNT_W'(1);

  // one restoring division step
  assign trial    = {div_rem_r, div_q_r[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, div_den_r});
  assign rem_nxt  = trial_ge ? CODE_W'(trial - {1'b0, div_den_r}) : trial[CODE_W-1:0];
  assign q_nxt    = {div_q_r[DIV_W-2:0], trial_ge};

  assign tenths_w = prod_r[PROD_W-1:16];
  assign out_load = (state_r == S_DONE) && (!out_valid || !out_stall);

  assign ring_rd = in_xfer;
  assign ring_we = (state_r == S_UPD);

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[slot_r] <= mag_r;
    if (ring_rd) rd_data_r <= ring_mem[slot_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_cnt_r == DCNT_W'(1)) begin
          if (!div_gain_r && edge_r && (q_nxt != '0)) state_nxt = S_DIV;
          else state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cell_min_r    <= CELL_MIN_RST;
      cell_max_r    <= CELL_MAX_RST;
      gain_r        <= GAIN_RST;
      sum_r         <= '0;
      count_r       <= '0;
      slot_r        <= '0;
      last_button_r <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CELL_MIN:  cell_min_r <= cfg_data[CODE_W-1:0];
          REG_CELL_MAX:  cell_max_r <= cfg_data[CODE_W-1:0];
          REG_INIT_GAIN: gain_r     <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (in_xfer) last_button_r <= in_button_level;

      if (state_r == S_UPD) begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        slot_r  <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
      end

      if (state_r == S_DIV && div_cnt_r == DCNT_W'(1)) begin
        if (div_gain_r) gain_r <= q_nxt[GAIN_W-1:0];
        else if (edge_r && q_nxt == '0) gain_r <= GAIN_SAT;
      end

      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag_r  <= mag_in;
      edge_r <= !in_button_level && last_button_r;
    end

    case (state_r)
      S_UPD: begin
        div_q_r    <= DIV_W'(sum_nxt);
        div_den_r  <= CODE_W'(count_nxt);
        div_rem_r  <= '0;
        div_cnt_r  <= DCNT_W'(DIV_W);
        div_gain_r <= 1'b0;
      end
      S_DIV: begin
        if (div_cnt_r == DCNT_W'(1)) begin
          if (!div_gain_r) begin
            avg_r <= q_nxt[MAG_W-1:0];
            // start the gain division on the averaged value
            div_q_r    <= CAL_NUM;
            div_den_r  <= CODE_W'(q_nxt[MAG_W-1:0]);
            div_rem_r  <= '0;
            div_cnt_r  <= DCNT_W'(DIV_W);
            div_gain_r <= 1'b1;
          end
        end else begin
          div_q_r   <= q_nxt;
          div_rem_r <= rem_nxt;
          div_cnt_r <= div_cnt_r - DCNT_W'(1);
        end
      end
      S_MUL: prod_r <= PROD_W'(avg_r) * PROD_W'(gain_r);
      default: ;
    endcase

    if (out_load) begin
      if (edge_r) out_status <= ST_CAL;
      else if ((CODE_W'(mag_r) > cell_max_r) || (CODE_W'(mag_r) < cell_min_r))
        out_status <= ST_CELL_FLT;
      else if (tenths_w > (PROD_W-16)'(TENTHS_LIM)) out_status <= ST_CAL_FLT;
      else out_status <= ST_NORMAL;

      out_o2_tenths    <= (tenths_w > (PROD_W-16)'(TENTHS_MAX)) ? TENTHS_MAX
                                                                 : tenths_w[TENTH_W-1:0];
      out_average_code <= CODE_W'(avg_r);
      out_gain         <= gain_r;
    end
  end

endmodule
`default_nettype wire
